/* rtl/bmt_pkg.sv */
package bmt_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned OpWidth    = 2;
  localparam int unsigned CountOutW  = 7;

  // Operation codes carried on the request side. Code 3 behaves as a query.
  typedef enum logic [OpWidth-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;   // capture the request, restart the scan flags
    logic clear_step;  // write an empty slot at the sweep address, advance
    logic scan_step;   // read the slot at the sweep address, advance
    logic commit;      // apply the insert or remove, update the count
    logic respond;     // load the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic addr_last;   // sweep address sits on the final slot
    logic out_busy;    // output register holds a result not yet taken
  } sts_t;

endpackage

/* rtl/bmt_ctrl.sv */
module bmt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  bmt_pkg::sts_t sts_i,
  output bmt_pkg::cmd_t cmd_o
);
  import bmt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_RESP
  } state_e;

  state_e state_q;

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.clear_step = (state_q == ST_CLEAR);
    cmd_o.load_item  = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.scan_step  = (state_q == ST_SCAN);
    cmd_o.commit     = (state_q == ST_COMMIT);
    cmd_o.respond    = (state_q == ST_RESP) && !sts_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          if (sts_i.addr_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (req_valid_i) state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (sts_i.addr_last) state_q <= ST_DRAIN;
        end
        ST_DRAIN:  state_q <= ST_COMMIT;
        ST_COMMIT: state_q <= ST_RESP;
        ST_RESP: begin
          if (!sts_i.out_busy) state_q <= ST_IDLE;
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/bmt_datapath.sv */
module bmt_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bmt_pkg::cmd_t                       cmd_i,
  output bmt_pkg::sts_t                       sts_o,
  input  logic [bmt_pkg::OpWidth-1:0]         op_i,
  input  logic signed [bmt_pkg::ValueWidth-1:0] item_value_i,
  input  logic                                cfg_wen_i,
  input  logic signed [bmt_pkg::ValueWidth-1:0] cfg_wdata_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                found_o,
  output logic                                accepted_o,
  output logic                                table_full_o,
  output logic [bmt_pkg::CountOutW-1:0]       entry_count_o
);
  import bmt_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [AW-1:0] LastAddr = AW'(CAPACITY - 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  // Slot word: valid mark on top, value below
  logic [ValueWidth:0]   mem_q [CAPACITY];
  logic [ValueWidth:0]   rdata_q;
  logic [ValueWidth:0]   mem_wdata;
  logic [AW-1:0]         mem_addr;
  logic                  mem_we;

  logic [AW-1:0]         addr_q;
  logic                  rd_pend_q;
  logic [AW-1:0]         rd_idx_q;
  logic                  hit_q, free_q;
  logic [AW-1:0]         hit_idx_q, free_idx_q;
  logic [OpWidth-1:0]    op_q;
  logic [ValueWidth-1:0] item_q;
  logic [ValueWidth-1:0] root_q;
  logic [CW-1:0]         count_q;
  logic                  found_q, acc_q;
  logic                  out_valid_q;
  logic                  do_insert, do_remove;

  assign sts_o.addr_last = (addr_q == LastAddr);
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

  assign do_insert = cmd_i.commit && (op_q == OP_INSERT) && free_q && (count_q < CapCount);
  assign do_remove = cmd_i.commit && (op_q == OP_REMOVE) && hit_q;

  always_comb begin
    mem_we    = cmd_i.clear_step || do_insert || do_remove;
    mem_addr  = addr_q;
    mem_wdata = '0;
    if (do_insert) begin
      mem_addr  = free_idx_q;
      mem_wdata = {1'b1, item_q};
    end else if (do_remove) begin
      mem_addr  = hit_idx_q;
    end
  end

  // Single-port slot store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end else if (cmd_i.scan_step) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      count_q     <= '0;
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wen_i) root_q <= cfg_wdata_i;
      if (cmd_i.clear_step || cmd_i.scan_step) begin
        addr_q <= sts_o.addr_last ? '0 : addr_q + 1'b1;
      end
      rd_pend_q <= cmd_i.scan_step;
      if (cmd_i.load_item) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else if (rd_pend_q) begin
        if (rdata_q[ValueWidth] && (rdata_q[ValueWidth-1:0] == item_q) && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!rdata_q[ValueWidth] && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (do_insert) begin
        count_q <= count_q + 1'b1;
      end else if (do_remove) begin
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (cmd_i.load_item) begin
      op_q   <= op_i;
      item_q <= item_value_i;
    end
    if (rd_pend_q && !cmd_i.load_item) begin
      if (rdata_q[ValueWidth] && (rdata_q[ValueWidth-1:0] == item_q) && !hit_q) begin
        hit_idx_q <= rd_idx_q;
      end
      if (!rdata_q[ValueWidth] && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.commit) begin
      found_q <= (item_q == root_q) || hit_q;
      acc_q   <= do_insert || do_remove;
    end
    if (cmd_i.respond) begin
      found_o       <= found_q;
      accepted_o    <= acc_q;
      table_full_o  <= (count_q == CapCount);
      entry_count_o <= CountOutW'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount)
    else $error("stored count beyond capacity");

  a_count_moves_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(count_q))
    else $error("stored count changed outside commit");

  a_free_slot_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (op_q == OP_INSERT) && (count_q < CapCount)) |-> free_q)
    else $error("scan found no free slot while count below capacity");

  a_no_overwrite_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.respond |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over one not yet taken");

endmodule

/* rtl/bounded_multiset_table_core.sv */
// A request is taken in the idle state, then the scan reads every slot of the single-port
// slot store in turn, a drain step takes the last read, the commit writes at most one slot
// and updates the count, and the response step loads the output register once it no longer
// holds an untaken result. A new request is taken only after the last one has loaded its
// result; a finished result waits in the output register while the next request is taken.
// Reset (rst_ni low, asynchronous) clears control, count and root; a clearing pass then
// empties every slot before the first request is taken.
module bounded_multiset_table_core #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] item_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  // result side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] found, [1] accepted, [2] table_full,
                                      // [9:3] entry_count, [15:10] zero
  // root value register
  input  logic        cfg_wen_i,
  input  logic [31:0] cfg_wdata_i
);
  import bmt_pkg::*;

  cmd_t                   cmd;
  sts_t                   sts;
  logic                   found, accepted, table_full;
  logic [CountOutW-1:0]   entry_count;

  // Controller: clearing pass, request intake, scan sequencing, commit, result hand-off
  bmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: slot store, sweep address, match and free-slot search, count, output register
  bmt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (s_axis_tuser),
    .item_value_i  (s_axis_tdata),
    .cfg_wen_i     (cfg_wen_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .found_o       (found),
    .accepted_o    (accepted),
    .table_full_o  (table_full),
    .entry_count_o (entry_count)
  );

  // Pack the result fields, lowest field first, pad to whole bytes
  assign m_axis_tdata = {6'b0, entry_count, table_full, accepted, found};

endmodule
